### sv/htcg_pkg.sv
// Shared types and constants for the hit time coincidence grouper.
// Used by every module of the block but htcg_ram; has no dependencies of its own.

package htcg_pkg;

   localparam int TIME_W       = 48;
   localparam int WIN_W        = 32;
   localparam int EVT_W        = 32;
   localparam int CLU_W        = 16;
   localparam int CSR_IDX_W    = 2;
   localparam int MAX_HITS_DEF = 64;
   localparam int QUEUE_DEPTH  = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_PROMPT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DELAYED = 2'd1;

   localparam logic [WIN_W-1:0] PROMPT_RESET  = 32'd100;
   localparam logic [WIN_W-1:0] DELAYED_RESET = 32'd100000;
   localparam logic [CLU_W-1:0] CLUSTER_MAX   = 16'hFFFF;

   typedef struct packed {
      logic [TIME_W-1:0] hit_time;
      logic              hit_dead;
   } hit_type;

   typedef struct packed {
      logic [WIN_W-1:0] prompt_window;
      logic [WIN_W-1:0] delayed_window;
   } cfg_type;

   typedef struct packed {
      logic              ignored;
      logic              new_event;
      logic              new_cluster;
      logic [EVT_W-1:0]  event_index;
      logic [CLU_W-1:0]  cluster_index;
      logic [TIME_W-1:0] closed_median;
      logic              median_valid;
   } result_type;

endpackage

### sv/htcg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read-first on a same-address write; no dependencies.

module htcg_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/htcg_front.sv
// Input stage: takes hit transfers, unpacks and registers them for the queue.
// Depends on htcg_pkg for the hit item type.

module htcg_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [htcg_pkg::TIME_W-1:0] req_tdata,
   input  logic [0:0]                 req_tuser,
   output logic                       push_valid,
   output htcg_pkg::hit_type          push_item,
   input  logic                       push_ready
);

   logic              valid_ff, valid_in;
   htcg_pkg::hit_type item_ff, item_in;
   logic              take;

   assign req_tready = !valid_ff || push_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in          = 1'b1;
         item_in.hit_time  = req_tdata;
         item_in.hit_dead  = req_tuser[0];
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

### sv/htcg_queue.sv
// Short first-word-fall-through queue between the front and back stages.
// Depends on htcg_pkg for the hit item type and the queue depth.

module htcg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  htcg_pkg::hit_type push_item,
   output logic              push_ready,
   output logic              pop_valid,
   output htcg_pkg::hit_type pop_item,
   input  logic              pop
);

   localparam int PtrW = $clog2(htcg_pkg::QUEUE_DEPTH);
   localparam int CntW = $clog2(htcg_pkg::QUEUE_DEPTH + 1);

   htcg_pkg::hit_type slot_ff [htcg_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   fill_ff, fill_in;
   logic              do_push, do_pop;

   assign push_ready = (fill_ff != CntW'(htcg_pkg::QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(htcg_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(htcg_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### sv/htcg_back.sv
// Grouping engine: cluster and event decisions, cluster time store, result register.
// Depends on htcg_pkg and instantiates htcg_ram.

module htcg_back #(
   parameter int MaxHits = htcg_pkg::MAX_HITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  htcg_pkg::cfg_type    cfg,
   input  logic                 q_valid,
   input  htcg_pkg::hit_type    q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   output htcg_pkg::result_type rsp_item,
   input  logic                 rsp_ready
);

   localparam int CW = $clog2(MaxHits + 1);
   localparam int AW = $clog2(MaxHits);
   localparam int TW = htcg_pkg::TIME_W;

   logic [CW-1:0]              count_ff, count_in;
   logic [CW-1:0]              mid_ff, mid_in;
   logic [TW-1:0]              head_ff, head_in;
   logic [TW-1:0]              last_ff, last_in;
   logic                       seen_ff, seen_in;
   logic [htcg_pkg::EVT_W-1:0] evt_ff, evt_in;
   logic [htcg_pkg::CLU_W-1:0] clu_ff, clu_in;
   logic                       byp_valid_ff, byp_valid_in;
   logic [TW-1:0]              byp_data_ff;
   logic                       out_valid_ff, out_valid_in;
   htcg_pkg::result_type       out_ff, out_in, res;

   logic                       take;
   logic [TW-1:0]              t, gap_last, gap_med, prompt_w, delayed_w, next_med;
   logic                       join_hit, stay;
   logic [CW-1:0]              rd_ptr_full;
   logic                       ram_we;
   logic [AW-1:0]              ram_wr_addr, ram_rd_addr;
   logic [TW-1:0]              ram_wr_data, ram_rd_data;

   htcg_ram #(
      .Width (TW),
      .Depth (MaxHits)
   ) u_times (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign take  = q_valid && (!out_valid_ff || rsp_ready);
   assign q_pop = take;
   assign t     = q_item.hit_time;

   assign prompt_w  = {{(TW - htcg_pkg::WIN_W){1'b0}}, cfg.prompt_window};
   assign delayed_w = {{(TW - htcg_pkg::WIN_W){1'b0}}, cfg.delayed_window};
   assign gap_last  = (t > last_ff) ? (t - last_ff) : '0;
   assign gap_med   = (t > head_ff) ? (t - head_ff) : '0;
   assign join_hit  = (gap_last < prompt_w);
   assign stay      = (gap_med < delayed_w);

   // The store is always read one entry past the median, so the next median is
   // ready when the cluster grows; a write to that entry last cycle is bypassed.
   assign rd_ptr_full = mid_ff + CW'(1);
   assign ram_rd_addr = rd_ptr_full[AW-1:0];
   assign next_med    = byp_valid_ff ? byp_data_ff : ram_rd_data;

   always_comb begin
      count_in    = count_ff;
      mid_in      = mid_ff;
      head_in     = head_ff;
      last_in     = last_ff;
      seen_in     = seen_ff;
      evt_in      = evt_ff;
      clu_in      = clu_ff;
      ram_we      = 1'b0;
      ram_wr_addr = count_ff[AW-1:0];
      ram_wr_data = t;
      res         = '0;

      if (take) begin
         if (q_item.hit_dead) begin
            res.ignored = 1'b1;
         end else if (!seen_ff) begin
            seen_in         = 1'b1;
            res.new_event   = 1'b1;
            res.new_cluster = 1'b1;
            evt_in          = '0;
            clu_in          = '0;
            ram_we          = 1'b1;
            ram_wr_addr     = '0;
            count_in        = CW'(1);
            mid_in          = '0;
            head_in         = t;
            last_in         = t;
         end else if (join_hit) begin
            if (count_ff < CW'(MaxHits)) begin
               ram_we   = 1'b1;
               count_in = count_ff + CW'(1);
               // An odd count turning even moves the median one entry up.
               if (count_ff[0]) begin
                  mid_in  = mid_ff + CW'(1);
                  head_in = (mid_ff == '0) ? t : next_med;
               end
            end
            last_in = t;
         end else begin
            res.closed_median = head_ff;
            res.median_valid  = 1'b1;
            res.new_cluster   = 1'b1;
            if (stay) begin
               if (clu_ff != htcg_pkg::CLUSTER_MAX) begin
                  clu_in = clu_ff + htcg_pkg::CLU_W'(1);
               end
            end else begin
               res.new_event = 1'b1;
               evt_in        = evt_ff + htcg_pkg::EVT_W'(1);
               clu_in        = '0;
            end
            ram_we      = 1'b1;
            ram_wr_addr = '0;
            count_in    = CW'(1);
            mid_in      = '0;
            head_in     = t;
            last_in     = t;
         end
      end

      res.event_index   = evt_in;
      res.cluster_index = clu_in;

      byp_valid_in = ram_we && (ram_wr_addr == ram_rd_addr);

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (take) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         mid_ff       <= '0;
         head_ff      <= '0;
         last_ff      <= '0;
         seen_ff      <= 1'b0;
         evt_ff       <= '0;
         clu_ff       <= '0;
         byp_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         mid_ff       <= mid_in;
         head_ff      <= head_in;
         last_ff      <= last_in;
         seen_ff      <= seen_in;
         evt_ff       <= evt_in;
         clu_ff       <= clu_in;
         byp_valid_ff <= byp_valid_in;
         out_valid_ff <= out_valid_in;
      end
      byp_data_ff <= ram_wr_data;
      out_ff      <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

endmodule

### sv/hit_time_coincidence_grouper.sv
// A hit's result passes the front register, the queue slot and the back stage's output
// register before it is presented; result back-pressure adds to that. One hit is taken
// per cycle while results are not stalled, and each is decided as it leaves the queue.
// Reset (synchronous, active high) clears the cluster, event and cluster counters and
// restores prompt_window to 100 and delayed_window to 100000; there is no clearing pass.

module hit_time_coincidence_grouper #(
   parameter int MaxHits = htcg_pkg::MAX_HITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Hit channel.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [47:0]                   req_tdata,  // [47:0] hit_time
   input  logic [0:0]                    req_tuser,  // [0] hit_dead
   // Result channel.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [31:0] event_index, [47:32] cluster_index, [95:48] closed_median
   output logic [95:0]                   rsp_tdata,
   // [0] ignored, [1] new_event, [2] new_cluster, [3] median_valid
   output logic [3:0]                    rsp_tuser,
   // Configuration writes.
   input  logic                          csr_we,
   input  logic [htcg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [htcg_pkg::WIN_W-1:0]    csr_wdata
);

   // The block is split into a front stage that takes hit transfers, a two-entry
   // queue, and a back stage that does the grouping. The queue lets the hit side keep
   // moving while the result side is stalled, until it fills, and the back stage's
   // output register lets it take the next hit in the cycle a waiting result is taken.

   htcg_pkg::cfg_type    cfg_ff, cfg_in;
   logic                 push_valid, push_ready;
   htcg_pkg::hit_type    push_item;
   logic                 q_valid, q_pop;
   htcg_pkg::hit_type    q_item;
   htcg_pkg::result_type rsp_item;

   // Window registers. Writes to indexes that name no register are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            htcg_pkg::REG_PROMPT:  cfg_in.prompt_window  = csr_wdata;
            htcg_pkg::REG_DELAYED: cfg_in.delayed_window = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prompt_window  <= htcg_pkg::PROMPT_RESET;
         cfg_ff.delayed_window <= htcg_pkg::DELAYED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   htcg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   htcg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (q_valid),
      .pop_item   (q_item),
      .pop        (q_pop)
   );

   // The back stage keeps the current cluster's times in a RAM and holds the
   // median in a register. A joining hit is compared against the last hit time;
   // a closing hit against the held median. Both compares and the counter updates
   // happen in the cycle the hit leaves the queue.
   htcg_back #(
      .MaxHits (MaxHits)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_item  (rsp_item),
      .rsp_ready (rsp_tready)
   );

   assign rsp_tdata = {rsp_item.closed_median, rsp_item.cluster_index, rsp_item.event_index};
   assign rsp_tuser = {rsp_item.median_valid, rsp_item.new_cluster,
                       rsp_item.new_event, rsp_item.ignored};

endmodule

### verif/hit_grouping_checker.sv
// Checker for the hit time coincidence grouper: watches the hit, result and register
// ports, predicts each hit's grouping decision and compares every result field.
// Depends on htcg_pkg for widths, register indexes, reset values and the result layout.

module hit_grouping_checker #(
   parameter int MaxHits = htcg_pkg::MAX_HITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [47:0]                    req_tdata,   // [47:0] hit_time
   input  logic [0:0]                     req_tuser,   // [0] hit_dead
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [31:0] event_index, [47:32] cluster_index, [95:48] closed_median
   input  logic [95:0]                    rsp_tdata,
   // [0] ignored, [1] new_event, [2] new_cluster, [3] median_valid
   input  logic [3:0]                     rsp_tuser,
   input  logic                           csr_we,
   input  logic [htcg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [htcg_pkg::WIN_W-1:0]     csr_wdata,
   output int                             fail_count,
   output int                             pending_count,
   output int                             checked_count,
   output int                             event_count,
   output int                             median_count
);

   htcg_pkg::cfg_type               windows;
   logic [htcg_pkg::TIME_W-1:0]     cluster_times [MaxHits];
   int                              stored_hits;
   logic [htcg_pkg::TIME_W-1:0]     last_hit_time;
   logic                            seen_live_hit;
   logic [htcg_pkg::EVT_W-1:0]      event_number;
   logic [htcg_pkg::CLU_W-1:0]      cluster_number;
   htcg_pkg::result_type            expected_groupings [$];

   // Distance from an earlier time, floored at zero when time runs backwards.
   function automatic logic [htcg_pkg::TIME_W-1:0] elapsed(
      input logic [htcg_pkg::TIME_W-1:0] t,
      input logic [htcg_pkg::TIME_W-1:0] since);
      return (t > since) ? t - since : '0;
   endfunction

   function automatic void open_cluster(input logic [htcg_pkg::TIME_W-1:0] t);
      cluster_times[0] = t;
      stored_hits      = 1;
      last_hit_time    = t;
   endfunction

   function automatic htcg_pkg::result_type predict_grouping(
      input logic [htcg_pkg::TIME_W-1:0] t,
      input logic dead);
      htcg_pkg::result_type r;
      int                   mid;
      r = '0;
      if (dead) begin
         r.ignored = 1'b1;
      end else if (!seen_live_hit) begin
         seen_live_hit  = 1'b1;
         r.new_event    = 1'b1;
         r.new_cluster  = 1'b1;
         event_number   = '0;
         cluster_number = '0;
         open_cluster(t);
      end else if (elapsed(t, last_hit_time) <
                   htcg_pkg::TIME_W'(windows.prompt_window)) begin
         // Joins the prompt cluster; the store stops filling once it is full.
         if (stored_hits < MaxHits) begin
            cluster_times[stored_hits] = t;
            stored_hits++;
         end
         last_hit_time = t;
      end else begin
         mid = stored_hits / 2;
         if (mid >= MaxHits) mid = MaxHits - 1;
         r.closed_median = cluster_times[mid];
         r.median_valid  = 1'b1;
         r.new_cluster   = 1'b1;
         if (elapsed(t, r.closed_median) <
             htcg_pkg::TIME_W'(windows.delayed_window)) begin
            if (cluster_number != htcg_pkg::CLUSTER_MAX) cluster_number++;
         end else begin
            r.new_event    = 1'b1;
            event_number   = event_number + 1'b1;
            cluster_number = '0;
         end
         open_cluster(t);
      end
      r.event_index   = event_number;
      r.cluster_index = cluster_number;
      return r;
   endfunction

   task automatic compare_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      htcg_pkg::result_type want;
      htcg_pkg::result_type got;
      htcg_pkg::result_type predicted;
      if (reset) begin
         windows.prompt_window  = htcg_pkg::PROMPT_RESET;
         windows.delayed_window = htcg_pkg::DELAYED_RESET;
         foreach (cluster_times[i]) cluster_times[i] = '0;
         stored_hits    = 0;
         last_hit_time  = '0;
         seen_live_hit  = 1'b0;
         event_number   = '0;
         cluster_number = '0;
         expected_groupings.delete();
         fail_count    = 0;
         checked_count = 0;
         event_count   = 0;
         median_count  = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == htcg_pkg::REG_PROMPT) windows.prompt_window = csr_wdata;
            else if (csr_index == htcg_pkg::REG_DELAYED) windows.delayed_window = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            predicted          = predict_grouping(req_tdata, req_tuser[0]);
            expected_groupings = {expected_groupings, predicted};
         end
         if (rsp_tvalid && rsp_tready) begin
            got.ignored       = rsp_tuser[0];
            got.new_event     = rsp_tuser[1];
            got.new_cluster   = rsp_tuser[2];
            got.median_valid  = rsp_tuser[3];
            got.event_index   = rsp_tdata[31:0];
            got.cluster_index = rsp_tdata[47:32];
            got.closed_median = rsp_tdata[95:48];
            if (expected_groupings.size() == 0) begin
               $error("result transfer with no hit waiting for it");
               fail_count++;
            end else begin
               want = expected_groupings.pop_front();
               compare_field("ignored", want.ignored, got.ignored);
               compare_field("new_event", want.new_event, got.new_event);
               compare_field("new_cluster", want.new_cluster, got.new_cluster);
               compare_field("event_index", want.event_index, got.event_index);
               compare_field("cluster_index", want.cluster_index, got.cluster_index);
               compare_field("closed_median", want.closed_median, got.closed_median);
               compare_field("median_valid", want.median_valid, got.median_valid);
               checked_count++;
               if (want.new_event) event_count++;
               if (want.median_valid) median_count++;
            end
         end
      end
      pending_count <= expected_groupings.size();
   end

endmodule

### verif/testbench.sv
// Top of the hit time coincidence grouper regression: clock, reset, hit stimulus,
// result back-pressure, register writes, watchdog and verdict.
// Depends on htcg_pkg, the grouper RTL and hit_grouping_checker.

module testbench;

   // Indexes with no register behind them; writes to them must change nothing.
   localparam logic [htcg_pkg::CSR_IDX_W-1:0] REG_SPARE_LO = 2'd2;
   localparam logic [htcg_pkg::CSR_IDX_W-1:0] REG_SPARE_HI = 2'd3;

   localparam logic [htcg_pkg::WIN_W-1:0]  WINDOW_MAX = '1;
   localparam logic [htcg_pkg::TIME_W-1:0] TIME_MAX   = '1;

   localparam int RESET_CYCLES  = 8;
   // The drain lets the block's pipeline go quiet after the last result.
   localparam int DRAIN_CYCLES  = 8;
   // Longest honest quiet stretch is a receiver stall run plus a sender gap plus
   // the drain, all well below this.
   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_HITS    = 195;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_MOSTLY,
      READY_RUNS
   } stall_mode_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic [47:0]                    req_tdata  = '0;   // [47:0] hit_time
   logic [0:0]                     req_tuser  = '0;   // [0] hit_dead
   logic                           rsp_tready = 1'b0;
   logic                           csr_we     = 1'b0;
   logic [htcg_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [htcg_pkg::WIN_W-1:0]     csr_wdata  = '0;
   logic                           req_tready;
   logic                           rsp_tvalid;
   // [31:0] event_index, [47:32] cluster_index, [95:48] closed_median
   logic [95:0]                    rsp_tdata;
   // [0] ignored, [1] new_event, [2] new_cluster, [3] median_valid
   logic [3:0]                     rsp_tuser;

   int fail_count;
   int pending_count;
   int checked_count;
   int event_count;
   int median_count;

   // Copies of the window registers, used only to aim the hit gaps at the
   // interesting boundaries of the current setting.
   logic [htcg_pkg::WIN_W-1:0]  prompt_now  = htcg_pkg::PROMPT_RESET;
   logic [htcg_pkg::WIN_W-1:0]  delayed_now = htcg_pkg::DELAYED_RESET;
   logic [htcg_pkg::TIME_W-1:0] time_base   = '0;
   int                          burst_left  = 0;
   int                          hits_sent   = 0;
   int                          idle_cycles = 0;
   stall_mode_type              stall_mode  = READY_ALWAYS;
   int                          stall_tick  = 0;
   int                          stall_hold  = 0;

   hit_time_coincidence_grouper u_dut (.*);

   hit_grouping_checker u_checker (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The receiver periodically switches at random between several stall habits: always
   // ready, a fair coin, mostly ready, and long runs of back-pressure. That way
   // stalls land on every phase of the block's pipeline, with clean stretches too.
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 128 == 0) stall_mode <= stall_mode_type'($urandom_range(0, 3));
      case (stall_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN:   rsp_tready <= ($urandom_range(0, 1) == 1);
         READY_MOSTLY: rsp_tready <= ($urandom_range(0, 9) != 0);
         default: begin
            if (stall_hold > 0) begin
               rsp_tready <= 1'b0;
               stall_hold <= stall_hold - 1;
            end else begin
               rsp_tready <= 1'b1;
               if ($urandom_range(0, 7) == 0) stall_hold <= $urandom_range(4, 16);
            end
         end
      endcase
   end

   // Watchdog: a long stretch with no transfer on either channel means a hang.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("hit_time_coincidence_grouper regression: fail");
         $finish;
      end
   end

   function automatic logic [htcg_pkg::TIME_W-1:0] random_time();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[htcg_pkg::TIME_W-1:0];
   endfunction

   // Picks the distance to the next hit, aimed at the current windows: most often
   // inside the prompt window, some right at its edge, some that close the cluster
   // but stay in the event, some that just leave the event, and a few huge jumps.
   function automatic logic [htcg_pkg::TIME_W-1:0] pick_step();
      logic [63:0] step;
      int          roll;
      roll = $urandom_range(0, 99);
      if (roll < 45)
         step = (prompt_now == 0) ? 64'd0 : 64'($urandom_range(0, prompt_now - 1));
      else if (roll < 52)
         step = 64'(prompt_now) - 64'((prompt_now != 0) && ($urandom_range(0, 1) == 1));
      else if (roll < 80)
         step = 64'(prompt_now) + 64'($urandom_range(0, delayed_now));
      else if (roll < 92)
         step = 64'(delayed_now) + 64'($urandom_range(0, 2000));
      else
         step = {$urandom, $urandom};
      return step[htcg_pkg::TIME_W-1:0];
   endfunction

   // One hit transfer. The sender works in bursts; between bursts it drops valid
   // for a random gap. Valid is only lowered when a real gap follows, so it is
   // never lowered and raised again in the same time step.
   task automatic send_hit(input logic [htcg_pkg::TIME_W-1:0] t, input logic dead);
      int pause;
      if (burst_left == 0) begin
         pause = $urandom_range(0, 6);
         if (pause > 0) begin
            req_tvalid <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 32);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= t;
      req_tuser  <= dead;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      hits_sent++;
   endtask

   task automatic write_reg(input logic [htcg_pkg::CSR_IDX_W-1:0] index,
                            input logic [htcg_pkg::WIN_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (index == htcg_pkg::REG_PROMPT) prompt_now = value;
      else if (index == htcg_pkg::REG_DELAYED) delayed_now = value;
   endtask

   // Stops the sender until every outstanding hit has its result back, then lets
   // the pipeline go quiet. It first lets the checker's count catch up with the
   // last hit transfer.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random traffic: mostly an ordered hit stream shaped by pick_step, with dead
   // hits, hits that step backwards and hits at random times mixed in.
   task automatic run_random_hits(input int count);
      int roll;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            send_hit(random_time(), 1'b1);
         end else if (roll < 12) begin
            send_hit(time_base - htcg_pkg::TIME_W'($urandom_range(0, 1000)), 1'b0);
         end else if (roll < 14) begin
            time_base = random_time();
            send_hit(time_base, 1'b0);
         end else begin
            time_base = time_base + pick_step();
            send_hit(time_base, 1'b0);
         end
      end
   endtask

   initial begin
      int cluster_size;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed hits under the reset windows (prompt 100, delayed 100000).
      // A dead hit before anything live reports zeroed counters.
      send_hit(TIME_MAX, 1'b1);
      // The first live hit opens event 0, cluster 0, with no median.
      send_hit(48'd0, 1'b0);
      send_hit(48'd50, 1'b0);
      send_hit(48'd99, 1'b0);
      // A gap of exactly the prompt window closes the cluster; the median is the
      // middle stored time and sits well inside the delayed window.
      send_hit(48'd199, 1'b0);
      // Time running backwards counts as no gap, so this hit joins.
      send_hit(48'd150, 1'b0);
      send_hit(48'd299, 1'b0);
      // Far away from the median: a new event.
      send_hit(48'd200_000, 1'b0);
      // Dead hits with alternating bit patterns leave the state alone.
      send_hit(48'hAAAA_AAAA_AAAA, 1'b1);
      send_hit(48'h5555_5555_5555, 1'b1);
      // Largest time: a new event; then a backwards hit joins it.
      send_hit(TIME_MAX, 1'b0);
      send_hit(48'd5, 1'b0);
      send_hit(TIME_MAX, 1'b0);
      // Backwards far below the median after the largest time opened a new event.
      send_hit(48'd0, 1'b0);
      send_hit(48'h5555_5555_5555, 1'b0);
      send_hit(48'hAAAA_AAAA_AAAA, 1'b0);
      drain_results();

      // Random phases, each under its own window setting. The sender pauses for
      // every result before each register change.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               // Writes to indexes with no register must leave the windows alone.
               write_reg(REG_SPARE_LO, $urandom);
               write_reg(REG_SPARE_HI, $urandom);
            end
            1: begin
               write_reg(htcg_pkg::REG_PROMPT, $urandom_range(1, 1000));
               write_reg(htcg_pkg::REG_DELAYED, $urandom_range(1000, 200_000));
            end
            2: begin
               // Nothing joins and nothing stays: every live hit opens an event.
               write_reg(htcg_pkg::REG_PROMPT, '0);
               write_reg(htcg_pkg::REG_DELAYED, '0);
            end
            3: begin
               write_reg(htcg_pkg::REG_PROMPT, WINDOW_MAX);
               write_reg(htcg_pkg::REG_DELAYED, WINDOW_MAX);
            end
            4: begin
               write_reg(htcg_pkg::REG_PROMPT, $urandom);
               write_reg(htcg_pkg::REG_DELAYED, $urandom);
            end
            5: begin
               write_reg(htcg_pkg::REG_PROMPT, 32'd1);
               write_reg(htcg_pkg::REG_DELAYED, 32'd2);
            end
            default: begin
               write_reg(htcg_pkg::REG_PROMPT, $urandom_range(1, 50));
               write_reg(htcg_pkg::REG_DELAYED, $urandom_range(50, 5000));
            end
         endcase
         if ($urandom_range(0, 1) == 1) time_base = random_time();
         run_random_hits(PHASE_HITS);
         drain_results();
      end

      // Clusters at least as big as the time store: the count saturates and the median
      // index must stay inside the store. Each cluster starts with a jump larger
      // than any prompt window.
      write_reg(htcg_pkg::REG_PROMPT, WINDOW_MAX);
      write_reg(htcg_pkg::REG_DELAYED, $urandom_range(0, 1 << 20));
      for (int c = 0; c < 3; c++) begin
         time_base    = time_base + 48'h2_0000_0000;
         cluster_size = $urandom_range(htcg_pkg::MAX_HITS_DEF, htcg_pkg::MAX_HITS_DEF + 40);
         for (int k = 0; k < cluster_size; k++) begin
            if ($urandom_range(0, 15) == 0) send_hit(random_time(), 1'b1);
            time_base = time_base + htcg_pkg::TIME_W'($urandom_range(0, 500));
            send_hit(time_base, 1'b0);
         end
      end
      time_base = time_base + 48'h2_0000_0000;
      send_hit(time_base, 1'b0);
      drain_results();

      $display("Sent %0d hits; checked %0d results, %0d opening events, %0d closing clusters.",
               hits_sent, checked_count, event_count, median_count);
      $display("Covered window extremes, dead and backward hits and time store overflow.");
      if (pending_count != 0) $error("%0d expected results never arrived", pending_count);
      if (fail_count == 0 && pending_count == 0)
         $display("hit_time_coincidence_grouper regression: pass");
      else
         $display("hit_time_coincidence_grouper regression: fail");
      $finish;
   end

endmodule

### files.f
sv/htcg_pkg.sv
sv/htcg_ram.sv
sv/htcg_front.sv
sv/htcg_queue.sv
sv/htcg_back.sv
sv/hit_time_coincidence_grouper.sv
verif/hit_grouping_checker.sv
verif/testbench.sv
